/* rtl/array_linked_list_free_stack_top_assert.svh */
// Assertion macros shared by the list block.
`ifndef ARRAY_LINKED_LIST_FREE_STACK_TOP_ASSERT_SVH
`define ARRAY_LINKED_LIST_FREE_STACK_TOP_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define ALFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold outside reset
`define ALFS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/alfs_pkg.sv */
// Types and constants of the linked list block.
package alfs_pkg;

  localparam int REQ_W     = 2;
  localparam int POS_W     = 8;
  localparam int PAYLOAD_W = 64;
  localparam int COUNT_W   = 9;

  localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } alfs_op_e;

  // command broadcast to every cell
  typedef struct packed {
    alfs_op_e               op;
    logic [PAYLOAD_W-1:0]   wdata;
  } alfs_cmd_t;

endpackage

/* rtl/alfs_if.sv */
// Request and response channel interfaces of the linked list block.
interface alfs_req_if import alfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [POS_W-1:0]     position;
  logic [PAYLOAD_W-1:0] payload_in;

  modport source (output valid, req_type, position, payload_in, input ready);
  modport sink   (input valid, req_type, position, payload_in, output ready);
endinterface

interface alfs_rsp_if import alfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAYLOAD_W-1:0] payload_out;
  logic                 status;
  logic [COUNT_W-1:0]   entry_count;

  modport source (output valid, payload_out, status, entry_count, input ready);
  modport sink   (input valid, payload_out, status, entry_count, output ready);
endinterface

/* rtl/alfs_cell.sv */
// One list cell: holds the entry at its list position and, if HAS_TAP is set, a read-out tap.
module alfs_cell import alfs_pkg::*; #(
  parameter int INDEX   = 0,
  parameter int IDX_W   = 8,
  parameter bit HAS_TAP = 1'b1
) (
  input  logic                 clk_i,
  input  alfs_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]     pos_i,
  input  logic [PAYLOAD_W-1:0] prev_data_i,
  input  logic [PAYLOAD_W-1:0] next_data_i,
  output logic [PAYLOAD_W-1:0] data_o,
  input  logic [POS_W-1:0]     rpos_i,
  input  logic [PAYLOAD_W-1:0] rd_i,
  output logic [PAYLOAD_W-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [PAYLOAD_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      OP_INSERT: begin
        if (MY_IDX > pos_i) begin
          data_d = prev_data_i;
        end else if (MY_IDX == pos_i) begin
          data_d = cmd_i.wdata;
        end
      end
      OP_DELETE: begin
        if (MY_IDX >= pos_i) begin
          data_d = next_data_i;
        end
      end
      OP_NONE: data_d = data_q;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  if (HAS_TAP) begin : g_tap
    logic [PAYLOAD_W-1:0] rd_q;
    // pick own entry on a hit, else pass the neighbor's value on
    always_ff @(posedge clk_i) begin
      rd_q <= (rpos_i == POS_W'(INDEX)) ? data_q : rd_i;
    end
    assign rd_o = rd_q;
  end else begin : g_no_tap
    assign rd_o = '0;
  end

endmodule

/* rtl/array_linked_list_free_stack_top.sv */
// An accepted item starts a walk along the read-out chain that carries the
// addressed entry through the cells one cell per cycle; once the walk has ended
// and the output is free, the result is registered. No item is taken meanwhile.
// Insert and delete shift the cells in the accept cycle.
// Reset empties the list at once; cell contents are not cleared.
module array_linked_list_free_stack_top import alfs_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alfs_req_if.sink    req_i,
  alfs_rsp_if.source  rsp_o
);

`include "array_linked_list_free_stack_top_assert.svh"

  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int READ_CELLS = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
  localparam int WALK_W     = $clog2(READ_CELLS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_e;

  state_e state_d, state_q;
  logic [WALK_W-1:0] cnt_d, cnt_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic out_valid_d, out_valid_q;

  logic [POS_W-1:0] rpos_q;
  logic st_d, st_q;
  logic rd_ok_d, rd_ok_q;
  logic [PAYLOAD_W-1:0] out_payload_q;
  logic out_status_q;
  logic [COUNT_W-1:0] out_count_q;

  logic accept, load;
  logic [CMP_W-1:0] pos_c, cnt_c;
  alfs_cmd_t cmd;
  logic [IDX_W-1:0] cmd_pos;

  logic [PAYLOAD_W-1:0] data [CAPACITY];
  logic [PAYLOAD_W-1:0] rd [CAPACITY];

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign pos_c       = CMP_W'(req_i.position);
  assign cnt_c       = CMP_W'(count_q);

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.wdata = req_i.payload_in;
    cmd_pos   = '0;
    count_d   = count_q;
    st_d      = ST_IGNORED;
    rd_ok_d   = 1'b0;
    unique case (req_i.req_type)
      REQ_READ: begin
        if (pos_c < cnt_c) begin
          st_d    = ST_DONE;
          rd_ok_d = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (count_q != CNT_W'(CAPACITY)) begin
          cmd.op  = OP_INSERT;
          cmd_pos = (pos_c > cnt_c) ? cnt_c[IDX_W-1:0] : pos_c[IDX_W-1:0];
          count_d = count_q + 1'b1;
          st_d    = ST_DONE;
        end
      end
      REQ_DELETE: begin
        if (pos_c < cnt_c) begin
          cmd.op  = OP_DELETE;
          cmd_pos = pos_c[IDX_W-1:0];
          count_d = count_q - 1'b1;
          st_d    = ST_DONE;
        end
      end
      default: ;
    endcase
    if (!accept) begin
      cmd.op  = OP_NONE;
      count_d = count_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PAYLOAD_W-1:0] prev_data, next_data, prev_rd;
    if (i == 0) begin : g_first
      assign prev_data = '0;
      assign prev_rd   = '0;
    end else begin : g_inner
      assign prev_data = data[i-1];
      assign prev_rd   = rd[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_body
      assign next_data = data[i+1];
    end
    alfs_cell #(
      .INDEX   (i),
      .IDX_W   (IDX_W),
      .HAS_TAP (i < READ_CELLS)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (cmd_pos),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (data[i]),
      .rpos_i      (rpos_q),
      .rd_i        (prev_rd),
      .rd_o        (rd[i])
    );
  end

  // walk until the addressed entry has reached the last tap
  assign load = (state_q == S_WALK) && (cnt_q == WALK_W'(READ_CELLS)) &&
                (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_WALK;
          cnt_d   = '0;
        end
      end
      S_WALK: begin
        if (cnt_q != WALK_W'(READ_CELLS)) begin
          cnt_d = cnt_q + 1'b1;
        end else if (load) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rpos_q  <= req_i.position;
      st_q    <= st_d;
      rd_ok_q <= rd_ok_d;
    end
    if (load) begin
      out_payload_q <= rd_ok_q ? rd[READ_CELLS-1] : '0;
      out_status_q  <= st_q;
      out_count_q   <= COUNT_W'(count_q);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.payload_out = out_payload_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;

  `ALFS_ASSERT(a_accept_starts_walk, accept |=> (state_q == S_WALK) && (cnt_q == '0), "accepted item did not start a walk")
  `ALFS_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY), "entry count above capacity")
  `ALFS_ASSERT(a_count_moves_on_accept, !$stable(count_q) |-> $past(accept), "entry count changed without an item")
  `ALFS_ASSERT(a_load_after_walk, $rose(out_valid_q) |-> $past(cnt_q) == WALK_W'(READ_CELLS), "result shown before the walk ended")

endmodule
